### rtl/sensor_frame_deframer_unit_macros.svh
// Assertion macros for the frame deframer RTL.
`ifndef SENSOR_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfd_pkg.sv
// Types, constants and register codes of the frame deframer.
package sfd_pkg;

  // Default payload store depth in bytes.
  localparam int unsigned PayloadDepthDef = 64;

  // Width of a frame length byte.
  localparam int unsigned FrameLenW = 8;

  // Reset values of the configuration registers.
  localparam logic [7:0] HeadByteRst    = 8'd239;
  localparam logic [6:0] MaxPayloadRst  = 7'd64;
  localparam logic [7:0] WantedMsgIdRst = 8'd81;
  localparam logic [6:0] WantedLenRst   = 7'd20;

  // Register word indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_HEAD_BYTE     = 2'd0,
    REG_MAX_PAYLOAD   = 2'd1,
    REG_WANTED_MSG_ID = 2'd2,
    REG_WANTED_LEN    = 2'd3
  } reg_idx_e;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_DEV     = 3'd1,
    PH_SYS     = 3'd2,
    PH_MSG     = 3'd3,
    PH_SEQ     = 3'd4,
    PH_LEN     = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_CHECK   = 3'd7
  } phase_e;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] head_byte;
    logic [6:0] max_payload;
    logic [7:0] wanted_msg_id;
    logic [6:0] wanted_len;
  } cfg_t;

  // One validated frame waiting for delivery.
  typedef struct packed {
    logic                 bank;
    logic [FrameLenW-1:0] len;
    logic [7:0]           seq;
    logic [7:0]           dev;
    logic [7:0]           sys;
  } desc_t;

  // One result item.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [7:0] frame_seq;
    logic [7:0] device_id;
    logic [7:0] system_id;
    logic       last;
  } out_item_t;

endpackage

### rtl/sfd_store.sv
// Two-bank payload store: one write port, one registered read port.
module sfd_store #(
  parameter int unsigned  PayloadDepth = sfd_pkg::PayloadDepthDef,
  localparam int unsigned AddrW        = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW:0]       wr_addr_i,
  input  logic [7:0]           wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW:0]       rd_addr_i,
  output logic [7:0]           rd_data_o
);

  localparam int unsigned Entries = 2 * (2 ** AddrW);

  logic [7:0] mem_q [Entries];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### rtl/sfd_front.sv
// Front end: parses the byte stream, stores payload and qualifies frames.
module sfd_front #(
  parameter int unsigned  PayloadDepth = sfd_pkg::PayloadDepthDef,
  localparam int unsigned AddrW        = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfd_pkg::cfg_t       cfg_i,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  output logic                wr_en_o,
  output logic [AddrW:0]      wr_addr_o,
  output logic [7:0]          wr_data_o,
  output logic                push_o,
  output sfd_pkg::desc_t      desc_o
);

  localparam int unsigned CntW  = $clog2(PayloadDepth + 1);
  localparam logic [8:0]  DepthC = 9'(PayloadDepth);

  sfd_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_inc;
  logic [7:0]      len_q;
  logic [7:0]      sum_q;
  logic [7:0]      dev_q, sys_q, msg_q, seq_q;
  logic            bank_q;
  logic            len_over;
  logic            payload_done;
  logic            frame_ok;

  // Length checks against the configured bound and the store depth.
  assign len_over = (byte_i > {1'b0, cfg_i.max_payload}) || ({1'b0, byte_i} > DepthC);
  assign count_inc    = count_q + 1'b1;
  assign payload_done = (8'(count_inc) >= len_q);
  assign frame_ok = (byte_i == sum_q) && (msg_q == cfg_i.wanted_msg_id)
                    && (len_q == {1'b0, cfg_i.wanted_len}) && (len_q != 8'd0);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (valid_i) begin
      case (phase_q)
        sfd_pkg::PH_HUNT: begin
          if (byte_i == cfg_i.head_byte) begin
            phase_d = sfd_pkg::PH_DEV;
          end
        end
        sfd_pkg::PH_DEV: phase_d = sfd_pkg::PH_SYS;
        sfd_pkg::PH_SYS: phase_d = sfd_pkg::PH_MSG;
        sfd_pkg::PH_MSG: phase_d = sfd_pkg::PH_SEQ;
        sfd_pkg::PH_SEQ: phase_d = sfd_pkg::PH_LEN;
        sfd_pkg::PH_LEN: begin
          if (byte_i == 8'd0) begin
            phase_d = sfd_pkg::PH_CHECK;
          end else if (len_over) begin
            phase_d = sfd_pkg::PH_HUNT;
          end else begin
            phase_d = sfd_pkg::PH_PAYLOAD;
          end
        end
        sfd_pkg::PH_PAYLOAD: begin
          if (payload_done) begin
            phase_d = sfd_pkg::PH_CHECK;
          end
        end
        sfd_pkg::PH_CHECK: phase_d = sfd_pkg::PH_HUNT;
        default: phase_d = sfd_pkg::PH_HUNT;
      endcase
    end
  end

  // Phase-driven outputs: store writes and frame hand-off.
  always_comb begin
    wr_en_o   = 1'b0;
    push_o    = 1'b0;
    case (phase_q)
      sfd_pkg::PH_PAYLOAD: wr_en_o = valid_i;
      sfd_pkg::PH_CHECK:   push_o  = valid_i && frame_ok;
      default: begin
        wr_en_o = 1'b0;
        push_o  = 1'b0;
      end
    endcase
  end

  assign wr_addr_o = {bank_q, count_q[AddrW-1:0]};
  assign wr_data_o = byte_i;
  assign desc_o    = '{bank: bank_q, len: len_q, seq: seq_q, dev: dev_q, sys: sys_q};

  // Phase, counters, checksum and bank select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_HUNT;
      count_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (valid_i) begin
        if (phase_q == sfd_pkg::PH_HUNT) begin
          sum_q <= byte_i;
        end else begin
          sum_q <= sum_q + byte_i;
        end
        if (phase_q == sfd_pkg::PH_LEN) begin
          len_q   <= byte_i;
          count_q <= '0;
        end else if (phase_q == sfd_pkg::PH_PAYLOAD) begin
          count_q <= payload_done ? '0 : count_inc;
        end
      end
      if (push_o) begin
        bank_q <= ~bank_q;
      end
    end
  end

  // Header bytes.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      case (phase_q)
        sfd_pkg::PH_DEV: dev_q <= byte_i;
        sfd_pkg::PH_SYS: sys_q <= byte_i;
        sfd_pkg::PH_MSG: msg_q <= byte_i;
        sfd_pkg::PH_SEQ: seq_q <= byte_i;
        default: ;
      endcase
    end
  end

endmodule

### rtl/sfd_queue.sv
// Two-entry queue of validated frame descriptors between front and back.
module sfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfd_pkg::desc_t desc_i,
  input  logic           pop_i,
  output sfd_pkg::desc_t desc_o,
  output logic           valid_o,
  output logic           full_o
);

  sfd_pkg::desc_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign desc_o  = slot_q[rd_ptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  // Descriptor storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/sfd_back.sv
// Back end: reads a delivered frame from the store and queues result items.
module sfd_back #(
  parameter int unsigned  PayloadDepth = sfd_pkg::PayloadDepthDef,
  localparam int unsigned AddrW        = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 desc_valid_i,
  input  sfd_pkg::desc_t       desc_i,
  output logic                 desc_pop_o,
  output logic                 rd_en_o,
  output logic [AddrW:0]       rd_addr_o,
  input  logic [7:0]           rd_data_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sfd_pkg::out_item_t   item_o
);

  localparam int unsigned CntW  = $clog2(PayloadDepth + 1);

  logic [CntW-1:0]    idx_q;
  logic [CntW-1:0]    idx_inc;
  logic               is_last;
  logic               issue;
  logic               pop_fire;
  logic [1:0]         occ;
  logic               inflight_q;
  sfd_pkg::out_item_t meta_q;
  sfd_pkg::out_item_t slot_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  // Issue a store read when the output queue has room for its data.
  assign pop_fire = pop_i && (cnt_q != 2'd0);
  assign occ      = cnt_q + {1'b0, inflight_q};
  assign issue    = desc_valid_i && ((occ < 2'd2) || pop_fire);
  assign idx_inc  = idx_q + 1'b1;
  assign is_last  = (8'(idx_inc) == desc_i.len);

  assign desc_pop_o = issue && is_last;
  assign rd_en_o    = issue;
  assign rd_addr_o  = {desc_i.bank, idx_q[AddrW-1:0]};

  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  // Byte counter and read-in-flight flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= issue;
      if (issue) begin
        idx_q <= is_last ? '0 : idx_inc;
      end
    end
  end

  // Frame fields that travel alongside the store read.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      meta_q <= '{payload_byte: 8'd0, byte_index: 6'(idx_q), frame_seq: desc_i.seq,
                  device_id: desc_i.dev, system_id: desc_i.sys, last: is_last};
    end
  end

  // Output queue storage; read data joins its fields on arrival.
  always_ff @(posedge clk_i) begin
    if (inflight_q) begin
      slot_q[wr_ptr_q] <= '{payload_byte: rd_data_i, byte_index: meta_q.byte_index,
                            frame_seq: meta_q.frame_seq, device_id: meta_q.device_id,
                            system_id: meta_q.system_id, last: meta_q.last};
    end
  end

  // Output queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (inflight_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_fire) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({inflight_q, pop_fire})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/sensor_frame_deframer_unit.sv
// Top level of the frame deframer: configuration registers and block wiring.
//
//   Channel   Direction  Handshake           Transfer when
//   input     in         push / full         push high and full low
//   result    out        pop / empty         pop high and empty low
//   config    in/out     psel/penable/pwrite psel, penable, pwrite and pready high
//
// The parser takes one received byte per cycle; input stalls (full high) only while
// two delivered frames wait in the descriptor queue, since each owns one store bank.
// A delivered frame's bytes go from the store to the result queue once it is queued,
// up to one per cycle while the queue has room, limited by the single read port.
// Reset is asynchronous and needs no clearing pass; the payload store is unreset.
// Result stalls backpressure only the back end until the descriptor queue fills.
module sensor_frame_deframer_unit #(
  parameter int unsigned PayloadDepth = sfd_pkg::PayloadDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic [7:0]  frame_seq_o,
  output logic [7:0]  device_id_o,
  output logic [7:0]  system_id_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "sensor_frame_deframer_unit_macros.svh"

  localparam int unsigned AddrW = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1;

  sfd_pkg::cfg_t      cfg_q;
  sfd_pkg::reg_idx_e  reg_idx;
  logic               cfg_wr;
  logic               in_fire;
  logic               st_we;
  logic [AddrW:0]     st_waddr;
  logic [7:0]         st_wdata;
  logic               st_re;
  logic [AddrW:0]     st_raddr;
  logic [7:0]         st_rdata;
  logic               q_push, q_pop, q_valid, q_full;
  sfd_pkg::desc_t     q_din, q_head;
  sfd_pkg::out_item_t item;

  // Configuration port: writes complete in the access phase, reads are immediate.
  assign pready  = 1'b1;
  assign reg_idx = sfd_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte     <= sfd_pkg::HeadByteRst;
      cfg_q.max_payload   <= sfd_pkg::MaxPayloadRst;
      cfg_q.wanted_msg_id <= sfd_pkg::WantedMsgIdRst;
      cfg_q.wanted_len    <= sfd_pkg::WantedLenRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        sfd_pkg::REG_HEAD_BYTE:     cfg_q.head_byte     <= pwdata[7:0];
        sfd_pkg::REG_MAX_PAYLOAD:   cfg_q.max_payload   <= pwdata[6:0];
        sfd_pkg::REG_WANTED_MSG_ID: cfg_q.wanted_msg_id <= pwdata[7:0];
        sfd_pkg::REG_WANTED_LEN:    cfg_q.wanted_len    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      sfd_pkg::REG_HEAD_BYTE:     prdata = 32'(cfg_q.head_byte);
      sfd_pkg::REG_MAX_PAYLOAD:   prdata = 32'(cfg_q.max_payload);
      sfd_pkg::REG_WANTED_MSG_ID: prdata = 32'(cfg_q.wanted_msg_id);
      sfd_pkg::REG_WANTED_LEN:    prdata = 32'(cfg_q.wanted_len);
      default:                    prdata = 32'd0;
    endcase
  end

  // Input transfer.
  assign full    = q_full;
  assign in_fire = push && !full;

  sfd_front #(.PayloadDepth(PayloadDepth)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (in_fire),
    .byte_i    (rx_byte_i),
    .wr_en_o   (st_we),
    .wr_addr_o (st_waddr),
    .wr_data_o (st_wdata),
    .push_o    (q_push),
    .desc_o    (q_din)
  );

  sfd_store #(.PayloadDepth(PayloadDepth)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_we),
    .wr_addr_i (st_waddr),
    .wr_data_i (st_wdata),
    .rd_en_i   (st_re),
    .rd_addr_i (st_raddr),
    .rd_data_o (st_rdata)
  );

  sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_din),
    .pop_i   (q_pop),
    .desc_o  (q_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  sfd_back #(.PayloadDepth(PayloadDepth)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (q_valid),
    .desc_i       (q_head),
    .desc_pop_o   (q_pop),
    .rd_en_o      (st_re),
    .rd_addr_o    (st_raddr),
    .rd_data_i    (st_rdata),
    .pop_i        (pop),
    .empty_o      (empty),
    .item_o       (item)
  );

  // Result fields.
  assign payload_byte_o = item.payload_byte;
  assign byte_index_o   = item.byte_index;
  assign frame_seq_o    = item.frame_seq;
  assign device_id_o    = item.device_id;
  assign system_id_o    = item.system_id;
  assign last_o         = item.last;

  // A frame is handed over only when the descriptor queue has room.
  `SFD_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, q_push, !q_full, "descriptor queue overflow")

  // Payload writes never land in the bank that the back end is reading.
  `SFD_ASSERT_IMP(a_bank_apart, clk_i, rst_ni, st_we && q_valid,
                  st_waddr[AddrW] != q_head.bank, "payload write hits the bank being read")

  // A handed-over frame is visible to the back end in the next cycle.
  `SFD_ASSERT_NXT(a_push_lands, clk_i, rst_ni, q_push, q_valid, "handed-over frame lost")

endmodule

### test/tb_sensor_frame_deframer_unit.sv
// Self-checking testbench for the sensor frame deframer: directed frames, then random traffic.
module tb_sensor_frame_deframer_unit;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic {
    ROW_NOISE = 1'b0,
    ROW_FRAME = 1'b1
  } row_kind_e;

  // One directed row: a stray byte or a whole frame, with its typed result count.
  typedef struct {
    row_kind_e  kind;
    logic [7:0] dev;
    logic [7:0] sys;
    logic [7:0] msg;
    logic [7:0] seq;
    logic [7:0] len;
    logic [7:0] fill;
    bit         bad_sum;
    int         exp_n;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        pop = 1'b0;
  logic        empty;
  logic [7:0]  payload_byte_o;
  logic [5:0]  byte_index_o;
  logic [7:0]  frame_seq_o;
  logic [7:0]  device_id_o;
  logic [7:0]  system_id_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  sensor_frame_deframer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .pop            (pop),
    .empty          (empty),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_seq_o    (frame_seq_o),
    .device_id_o    (device_id_o),
    .system_id_o    (system_id_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser mirror, starting from the reset state.
  sfd_pkg::cfg_t   setting = '{head_byte: sfd_pkg::HeadByteRst,
                               max_payload: sfd_pkg::MaxPayloadRst,
                               wanted_msg_id: sfd_pkg::WantedMsgIdRst,
                               wanted_len: sfd_pkg::WantedLenRst};
  sfd_pkg::phase_e mirror_phase = sfd_pkg::PH_HUNT;
  logic [6:0] mirror_count = '0;
  logic [7:0] mirror_len = '0;
  logic [7:0] mirror_hdr [4] = '{default: 8'h00};
  logic [7:0] mirror_sum = '0;
  logic [7:0] mirror_store [sfd_pkg::PayloadDepthDef];

  // Payload bytes the block still owes, oldest first.
  sfd_pkg::out_item_t pending_payload [$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int payload_predicted = 0;
  int payload_seen = 0;
  int settings_used = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 61;

  frame_row_t directed_rows [5] = '{
    '{ROW_NOISE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0},
    // Device id equal to the head value must be taken as plain data.
    '{ROW_FRAME, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF, 1'b0, 1},
    // Zero length jumps to the checksum and is never delivered.
    '{ROW_FRAME, 8'h12, 8'h34, 8'h00, 8'h56, 8'h00, 8'h00, 1'b0, 0},
    // Length above the bound drops the frame after the length byte.
    '{ROW_FRAME, 8'h01, 8'h02, 8'h00, 8'h03, 8'h03, 8'h00, 1'b0, 0},
    '{ROW_FRAME, 8'hA5, 8'h5A, 8'h00, 8'h80, 8'h01, 8'h00, 1'b1, 0}
  };

  // Prints one line per mismatch and keeps the count.
  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("ERROR: %s", what);
  endtask

  // Effective payload length bound.
  function automatic int unsigned length_bound();
    return (setting.max_payload > sfd_pkg::PayloadDepthDef) ? sfd_pkg::PayloadDepthDef
                                                            : setting.max_payload;
  endfunction

  // Advances the mirror by one accepted byte and queues any payload it releases.
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned        n;
    sfd_pkg::out_item_t item;
    case (mirror_phase)
      sfd_pkg::PH_HUNT: begin
        if (b == setting.head_byte) begin
          mirror_sum = b;
          mirror_phase = sfd_pkg::PH_DEV;
        end
      end
      sfd_pkg::PH_DEV, sfd_pkg::PH_SYS, sfd_pkg::PH_MSG, sfd_pkg::PH_SEQ: begin
        mirror_hdr[int'(mirror_phase) - 1] = b;
        mirror_sum = mirror_sum + b;
        mirror_phase = sfd_pkg::phase_e'(mirror_phase + 3'd1);
      end
      sfd_pkg::PH_LEN: begin
        mirror_len = b;
        mirror_sum = mirror_sum + b;
        mirror_count = '0;
        if (b == 8'd0) mirror_phase = sfd_pkg::PH_CHECK;
        else if (b > length_bound()) mirror_phase = sfd_pkg::PH_HUNT;
        else mirror_phase = sfd_pkg::PH_PAYLOAD;
      end
      sfd_pkg::PH_PAYLOAD: begin
        mirror_store[mirror_count[5:0]] = b;
        mirror_sum = mirror_sum + b;
        mirror_count = mirror_count + 7'd1;
        if ({1'b0, mirror_count} >= mirror_len) begin
          mirror_count = '0;
          mirror_phase = sfd_pkg::PH_CHECK;
        end
      end
      default: begin
        mirror_phase = sfd_pkg::PH_HUNT;
        mirror_count = '0;
        if (b == mirror_sum && mirror_hdr[2] == setting.wanted_msg_id &&
            mirror_len == {1'b0, setting.wanted_len}) begin
          n = (mirror_len > sfd_pkg::PayloadDepthDef) ? sfd_pkg::PayloadDepthDef : mirror_len;
          for (int unsigned i = 0; i < n; i++) begin
            item.payload_byte = mirror_store[i];
            item.byte_index = i[5:0];
            item.frame_seq = mirror_hdr[3];
            item.device_id = mirror_hdr[0];
            item.system_id = mirror_hdr[1];
            item.last = (i + 1 == n);
            pending_payload.push_back(item);
            payload_predicted++;
          end
        end
      end
    endcase
  endfunction

  // Offers one byte, idling first at random, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    deframe_byte(b);
  endtask

  // Sends a frame; the body and checksum are left out when the length is over the bound.
  task automatic send_frame(input logic [7:0] dev, input logic [7:0] sys,
                            input logic [7:0] msg, input logic [7:0] seq,
                            input logic [7:0] len, input bit rand_fill,
                            input logic [7:0] fill, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = setting.head_byte + dev + sys + msg + seq + len;
    frames_sent++;
    send_byte(setting.head_byte);
    send_byte(dev);
    send_byte(sys);
    send_byte(msg);
    send_byte(seq);
    send_byte(len);
    if (len > length_bound()) return;
    for (int i = 0; i < len; i++) begin
      b = rand_fill ? 8'($urandom) : fill;
      sum = sum + b;
      send_byte(b);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Waits until every owed payload byte has arrived, then lets the pipeline settle.
  task automatic wait_drained();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (pending_payload.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_payload.size() != 0) begin
      note_mismatch($sformatf("%0d payload bytes never arrived", pending_payload.size()));
      pending_payload.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Writes one register over the configuration port, then reads it back.
  task automatic cfg_write(input sfd_pkg::reg_idx_e idx, input logic [7:0] val);
    logic [31:0] data;
    logic [31:0] want;
    data = ($urandom & 32'hFFFF_FF00) | {24'h0, val};
    if (idx == sfd_pkg::REG_MAX_PAYLOAD || idx == sfd_pkg::REG_WANTED_LEN) begin
      data[7] = 1'($urandom_range(0, 1));
      want = {25'h0, data[6:0]};
    end else begin
      want = {24'h0, data[7:0]};
    end
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      sfd_pkg::REG_HEAD_BYTE:     setting.head_byte = data[7:0];
      sfd_pkg::REG_MAX_PAYLOAD:   setting.max_payload = data[6:0];
      sfd_pkg::REG_WANTED_MSG_ID: setting.wanted_msg_id = data[7:0];
      sfd_pkg::REG_WANTED_LEN:    setting.wanted_len = data[6:0];
      default: ;
    endcase
    // Read back the same register.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want)
      note_mismatch($sformatf("register %s read %08h, expected %08h", idx.name(), prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Programs all four registers for the next phase.
  task automatic apply_setting(input logic [7:0] head, input logic [6:0] max_len,
                               input logic [7:0] msg, input logic [6:0] want_len);
    cfg_write(sfd_pkg::REG_HEAD_BYTE, head);
    cfg_write(sfd_pkg::REG_MAX_PAYLOAD, {1'b0, max_len});
    cfg_write(sfd_pkg::REG_WANTED_MSG_ID, msg);
    cfg_write(sfd_pkg::REG_WANTED_LEN, {1'b0, want_len});
    settings_used++;
  endtask

  // Sends a random mix of frames, mostly well formed, and stray bytes until the budget is used.
  task automatic random_traffic(input int budget);
    int         start;
    int unsigned pick;
    logic [7:0] len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(8'($urandom), 8'($urandom), setting.wanted_msg_id, 8'($urandom),
                   {1'b0, setting.wanted_len}, 1'b1, 8'h00, 1'b0);
      end else if (pick < 73) begin
        send_frame(8'($urandom), 8'($urandom), setting.wanted_msg_id, 8'($urandom),
                   {1'b0, setting.wanted_len}, 1'b1, 8'h00, 1'b1);
      end else if (pick < 80) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   {1'b0, setting.wanted_len}, 1'b1, 8'h00, 1'b0);
      end else if (pick < 88) begin
        len = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                          : 8'($urandom_range(0, length_bound() + 2));
        send_frame(8'($urandom), 8'($urandom), setting.wanted_msg_id, 8'($urandom),
                   len, 1'b1, 8'h00, 1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        // A head followed by a few stray bytes leaves the parser mid-frame.
        send_byte(setting.head_byte);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  // Result side: random pop and a field-by-field check of every transfer.
  always @(posedge clk_i) begin
    sfd_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      payload_seen++;
      if (pending_payload.size() == 0) begin
        note_mismatch($sformatf("unexpected payload byte %02h index %0d",
                                payload_byte_o, byte_index_o));
      end else begin
        want = pending_payload.pop_front();
        if (payload_byte_o !== want.payload_byte || byte_index_o !== want.byte_index ||
            frame_seq_o !== want.frame_seq || device_id_o !== want.device_id ||
            system_id_o !== want.system_id || last_o !== want.last)
          note_mismatch($sformatf(
            {"got byte %02h idx %0d seq %02h dev %02h sys %02h last %0b, ",
             "want %02h %0d %02h %02h %02h %0b"},
            payload_byte_o, byte_index_o, frame_seq_o, device_id_o, system_id_o, last_o,
            want.payload_byte, want.byte_index, want.frame_seq, want.device_id,
            want.system_id, want.last));
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin
    int before_n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under a small bound and the all-ones head value.
    apply_setting(8'hFF, 7'd2, 8'h00, 7'd1);
    foreach (directed_rows[i]) begin
      before_n = payload_predicted;
      if (directed_rows[i].kind == ROW_NOISE) begin
        send_byte(directed_rows[i].dev);
      end else begin
        send_frame(directed_rows[i].dev, directed_rows[i].sys, directed_rows[i].msg,
                   directed_rows[i].seq, directed_rows[i].len, 1'b0,
                   directed_rows[i].fill, directed_rows[i].bad_sum);
      end
      if (payload_predicted - before_n != directed_rows[i].exp_n)
        note_mismatch($sformatf("directed row %0d released %0d bytes, table says %0d",
                                i, payload_predicted - before_n, directed_rows[i].exp_n));
    end
    wait_drained();

    // Random phases; idle pattern changes every two settings.
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 61;
      end else if (p < 4) begin
        send_idle_pct = 61;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: apply_setting(8'h00, 7'd127, 8'hFF, 7'd64);
        1: apply_setting(8'($urandom), 7'd1, 8'($urandom), 7'd1);
        2: apply_setting(8'($urandom), 7'd0, 8'($urandom), 7'd0);
        3: begin
          setting.max_payload = 7'($urandom_range(1, 64));
          apply_setting(8'($urandom), setting.max_payload, 8'($urandom),
                        7'($urandom_range(1, setting.max_payload)));
        end
        4: apply_setting(8'($urandom), 7'd64, 8'($urandom), 7'd127);
        default: apply_setting(8'($urandom), 7'($urandom_range(8, 64)), 8'($urandom),
                               7'($urandom_range(1, 8)));
      endcase
      random_traffic(10);
      wait_drained();
    end

    $display("Ran %0d bytes in %0d frames over %0d register settings.",
             bytes_sent, frames_sent, settings_used);
    $display("Checked %0d delivered payload bytes against the parser mirror.", payload_seen);
    if (mismatch_count == 0) begin
      $display("PASS sensor_frame_deframer_unit");
    end else begin
      $display("FAIL sensor_frame_deframer_unit");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAIL sensor_frame_deframer_unit");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_store.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/sensor_frame_deframer_unit.sv
test/tb_sensor_frame_deframer_unit.sv
